// ===== sv/ppte_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers of the piecewise trajectory evaluator
package ppte_pkg;

  localparam int MAX_SEGMENTS_DEF = 16;
  localparam int COEFF_COUNT_DEF  = 8;
  localparam int MAX_DERIV_ORDER  = 4;

  localparam int FALL_W    = 26;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] REQ_TIMING = 2'd0;
  localparam logic [1:0] REQ_COEF   = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_DUR = 2'd1;

  localparam logic [24:0] TAU_ONE      = 25'h1000000;
  localparam logic [57:0] TAU_HALF     = 58'h800000;
  localparam logic [62:0] MAG_CAP      = 63'h4000000000000000;
  localparam logic [63:0] NORM_LIMIT   = 64'h0040000000000000;
  localparam logic [62:0] OUT_POS_MAX  = 63'h00007FFFFFFFFFFF;
  localparam logic [62:0] OUT_NEG_MAG  = 63'h0000800000000000;
  localparam logic [47:0] OUT_POS_MAX48 = 48'h7FFFFFFFFFFF;
  localparam logic [47:0] OUT_NEG_MAG48 = 48'h800000000000;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [3:0]         segment_index;
    logic [2:0]         power_index;
    logic [31:0]        start_time;
    logic [31:0]        seg_duration;
    logic signed [31:0] coef_x;
    logic signed [31:0] coef_y;
    logic signed [31:0] coef_z;
    logic [31:0]        query_time;
    logic [2:0]         deriv_order;
  } ppte_in_t;

  typedef struct packed {
    logic signed [47:0] value_x;
    logic signed [47:0] value_y;
    logic signed [47:0] value_z;
    logic [3:0]         found_segment;
    logic               result_valid;
  } ppte_out_t;

  // p * (p-1) * ... over k factors
  function automatic logic [FALL_W-1:0] falling(input logic [3:0] p, input logic [2:0] k);
    logic [31:0] r;
    r = 32'd1;
    for (int i = 0; i < 7; i++) begin
      if (i < int'(k)) begin
        r = 32'(r * (32'(p) - 32'(i)));
      end
    end
    return r[FALL_W-1:0];
  endfunction

endpackage

// ===== sv/ppte_ram.sv =====
`timescale 1ns / 1ps
// generic single-write single-read ram with registered read data
module ppte_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/piecewise_polynomial_trajectory_eval.sv =====
`timescale 1ns / 1ps
// piecewise degree-7 trajectory evaluator top level
// table writes give no result; busy stays low
// a query runs the one-bit-per-cycle divider for tau (25 steps), the read, multiply and
//   add states of each horner term and, for derivative order k, k divider scale steps
//   per axis (79 steps each)
// result strobe is registered from the finishing state; the receiver cannot stall
// synchronous active-low reset clears control and config; table contents stay undefined
module piecewise_polynomial_trajectory_eval #(
  parameter int MAX_SEGMENTS = ppte_pkg::MAX_SEGMENTS_DEF,
  parameter int COEFF_COUNT  = ppte_pkg::COEFF_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  ppte_pkg::ppte_in_t                 in_data,
  output logic                               out_valid,
  output ppte_pkg::ppte_out_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ppte_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_wdata
);

  localparam int SEG_AW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int COEF_D  = MAX_SEGMENTS * COEFF_COUNT;
  localparam int COEF_AW = $clog2(COEF_D);
  localparam int P_W     = $clog2(COEFF_COUNT);
  localparam int FW      = ppte_pkg::FALL_W;

  typedef enum logic [15:0] {
    ST_IDLE     = 16'h0001,
    ST_SRCH     = 16'h0002,
    ST_SRCH_CMP = 16'h0004,
    ST_T_PREP   = 16'h0008,
    ST_T_DIV    = 16'h0010,
    ST_H_INIT   = 16'h0020,
    ST_H_RD     = 16'h0040,
    ST_H_MUL    = 16'h0080,
    ST_H_ADD    = 16'h0100,
    ST_NORM     = 16'h0200,
    ST_S_SETUP  = 16'h0400,
    ST_S_Q      = 16'h0800,
    ST_S_QEND   = 16'h1000,
    ST_S_R      = 16'h2000,
    ST_S_REND   = 16'h4000,
    ST_FIN      = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  logic [4:0]  segment_count_r, segment_count_nxt;
  logic [31:0] total_duration_r, total_duration_nxt;

  logic [31:0]      t_r, t_nxt;
  logic [2:0]       k_r, k_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic             res_ok_r, res_ok_nxt;
  logic [31:0]      dur_r, dur_nxt;
  logic [24:0]      tau_r, tau_nxt;
  logic [P_W-1:0]   p_r, p_nxt;
  logic [FW-1:0]    fall_r, fall_nxt;

  logic signed [63:0] acc_r [3];
  logic signed [63:0] acc_nxt [3];
  logic [56:0]        ph_r [3];
  logic [56:0]        ph_nxt [3];
  logic [56:0]        pl_r [3];
  logic [56:0]        pl_nxt [3];
  logic               sgn_r [3];
  logic               sgn_nxt [3];
  logic signed [58:0] term_r [3];
  logic signed [58:0] term_nxt [3];
  logic               neg_r [3];
  logic               neg_nxt [3];
  logic [62:0]        mag_r [3];
  logic [62:0]        mag_nxt [3];

  logic [1:0]  ax_r, ax_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [45:0] q1_r, q1_nxt;

  logic [31:0] div_rem_r, div_rem_nxt;
  logic [63:0] div_dvd_r, div_dvd_nxt;
  logic [63:0] div_quo_r, div_quo_nxt;
  logic [6:0]  div_cnt_r, div_cnt_nxt;

  logic                out_valid_r, out_valid_nxt;
  ppte_pkg::ppte_out_t out_data_r, out_data_nxt;

  // memory ports
  logic                seg_wr_en, seg_rd_en;
  logic [SEG_AW-1:0]   seg_wr_addr, seg_rd_addr;
  logic [63:0]         seg_rdata;
  logic                coef_wr_en, coef_rd_en;
  logic [COEF_AW-1:0]  coef_wr_addr, coef_rd_addr;
  logic [95:0]         coef_rdata;

  // lane datapath
  logic [31:0] coef_rd [3];
  logic [63:0] acc_abs [3];
  logic [57:0] tau_rnd [3];
  logic [63:0] tau_prod [3];
  logic [63:0] acc_step [3];
  logic [62:0] norm_mag [3];
  logic [47:0] sat_mag [3];
  logic [47:0] sat_val [3];

  // shared divider step
  logic        div_run;
  logic [32:0] div_trial;
  logic        div_ge;
  logic [32:0] div_diff;

  logic             accept;
  logic [CNT_W-1:0] n_w, mid_w;
  logic [31:0]      seg_start_w, seg_dur_w, durp_w, local_w;
  logic [56:0]      tau_num_w;
  logic [47:0]      frac_num_w;
  logic [62:0]      scaled_w;
  logic             last_step, last_ax;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign seg_wr_en   = accept && (in_data.req_type == ppte_pkg::REQ_TIMING) &&
                       (32'(in_data.segment_index) < MAX_SEGMENTS);
  assign seg_wr_addr = SEG_AW'(in_data.segment_index);
  assign coef_wr_en  = accept && (in_data.req_type == ppte_pkg::REQ_COEF) &&
                       (32'(in_data.segment_index) < MAX_SEGMENTS) &&
                       (32'(in_data.power_index) < COEFF_COUNT);
  assign coef_wr_addr = COEF_AW'(32'(in_data.segment_index) * COEFF_COUNT +
                                 32'(in_data.power_index));
  assign coef_rd_addr = COEF_AW'(32'(lo_r) * COEFF_COUNT + 32'(p_r));

  ppte_ram #(.DATA_W(64), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
    .clk     (clk),
    .wr_en   (seg_wr_en),
    .wr_addr (seg_wr_addr),
    .wr_data ({in_data.start_time, in_data.seg_duration}),
    .rd_en   (seg_rd_en),
    .rd_addr (seg_rd_addr),
    .rd_data (seg_rdata)
  );

  ppte_ram #(.DATA_W(96), .DEPTH(COEF_D)) u_coef_ram (
    .clk     (clk),
    .wr_en   (coef_wr_en),
    .wr_addr (coef_wr_addr),
    .wr_data ({in_data.coef_x, in_data.coef_y, in_data.coef_z}),
    .rd_en   (coef_rd_en),
    .rd_addr (coef_rd_addr),
    .rd_data (coef_rdata)
  );

  assign div_run   = (state_r == ST_T_DIV) || (state_r == ST_S_Q) || (state_r == ST_S_R);
  assign div_trial = {div_rem_r, div_dvd_r[63]};
  assign div_ge    = (div_trial >= {1'b0, dur_r});
  assign div_diff  = div_trial - {1'b0, dur_r};

  assign n_w   = (32'(segment_count_r) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS)
                                                       : CNT_W'(segment_count_r);
  assign mid_w = CNT_W'((32'(lo_r) + 32'(hi_r)) >> 1);

  assign seg_start_w = seg_rdata[63:32];
  assign seg_dur_w   = seg_rdata[31:0];
  assign durp_w      = (seg_dur_w == 32'd0) ? 32'd1 : seg_dur_w;
  always_comb begin
    local_w = (t_r < seg_start_w) ? 32'd0 : (t_r - seg_start_w);
    if (local_w > durp_w) begin
      local_w = durp_w;
    end
  end
  assign tau_num_w  = {1'b0, local_w, 24'd0} + 57'(durp_w >> 1);
  assign frac_num_w = {div_rem_r, 16'd0} + 48'(dur_r >> 1);
  assign scaled_w   = {1'b0, q1_r, 16'd0} + 63'(div_quo_r[15:0]);
  assign last_step  = (32'(step_r) + 32'd1 >= 32'(k_r));
  assign last_ax    = (ax_r == 2'd2);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      coef_rd[i]  = coef_rdata[95 - 32 * i -: 32];
      acc_abs[i]  = acc_r[i][63] ? 64'(-acc_r[i]) : 64'(acc_r[i]);
      tau_rnd[i]  = {1'b0, pl_r[i]} + ppte_pkg::TAU_HALF;
      tau_prod[i] = {ph_r[i][55:0], 8'd0} + {30'd0, tau_rnd[i][57:24]};
      acc_step[i] = (sgn_r[i] ? (64'd0 - tau_prod[i]) : tau_prod[i]) +
                    {{5{term_r[i][58]}}, term_r[i]};
      norm_mag[i] = (acc_abs[i] >= ppte_pkg::NORM_LIMIT) ? ppte_pkg::MAG_CAP
                                                         : {1'b0, acc_abs[i][53:0], 8'd0};
      if (neg_r[i]) begin
        sat_mag[i] = (mag_r[i] > ppte_pkg::OUT_NEG_MAG) ? ppte_pkg::OUT_NEG_MAG48
                                                        : mag_r[i][47:0];
        sat_val[i] = 48'd0 - sat_mag[i];
      end else begin
        sat_mag[i] = (mag_r[i] > ppte_pkg::OUT_POS_MAX) ? ppte_pkg::OUT_POS_MAX48
                                                        : mag_r[i][47:0];
        sat_val[i] = sat_mag[i];
      end
    end
  end

  always_comb begin
    state_nxt          = state_r;
    segment_count_nxt  = segment_count_r;
    total_duration_nxt = total_duration_r;
    t_nxt      = t_r;
    k_nxt      = k_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    res_ok_nxt = res_ok_r;
    dur_nxt    = dur_r;
    tau_nxt    = tau_r;
    p_nxt      = p_r;
    fall_nxt   = fall_r;
    for (int i = 0; i < 3; i++) begin
      acc_nxt[i]  = acc_r[i];
      ph_nxt[i]   = ph_r[i];
      pl_nxt[i]   = pl_r[i];
      sgn_nxt[i]  = sgn_r[i];
      term_nxt[i] = term_r[i];
      neg_nxt[i]  = neg_r[i];
      mag_nxt[i]  = mag_r[i];
    end
    ax_nxt        = ax_r;
    step_nxt      = step_r;
    q1_nxt        = q1_r;
    div_rem_nxt   = div_rem_r;
    div_dvd_nxt   = div_dvd_r;
    div_quo_nxt   = div_quo_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    seg_rd_en     = 1'b0;
    seg_rd_addr   = SEG_AW'(lo_r);
    coef_rd_en    = 1'b0;

    if (cfg_valid) begin
      unique case (cfg_index)
        ppte_pkg::CFG_SEG_COUNT: segment_count_nxt  = cfg_wdata[4:0];
        ppte_pkg::CFG_TOTAL_DUR: total_duration_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (div_run) begin
      div_rem_nxt = div_ge ? div_diff[31:0] : div_trial[31:0];
      div_dvd_nxt = {div_dvd_r[62:0], 1'b0};
      div_quo_nxt = {div_quo_r[62:0], div_ge};
      div_cnt_nxt = div_cnt_r - 7'd1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.req_type == ppte_pkg::REQ_QUERY)) begin
          t_nxt      = (in_data.query_time > total_duration_r) ? total_duration_r
                                                               : in_data.query_time;
          k_nxt      = in_data.deriv_order;
          lo_nxt     = '0;
          hi_nxt     = n_w;
          res_ok_nxt = 1'b0;
          state_nxt  = (n_w == '0) ? ST_FIN : ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (32'(lo_r) + 32'd1 < 32'(hi_r)) begin
          seg_rd_en   = 1'b1;
          seg_rd_addr = SEG_AW'(mid_w);
          mid_nxt     = mid_w;
          state_nxt   = ST_SRCH_CMP;
        end else if (32'(k_r) > ppte_pkg::MAX_DERIV_ORDER) begin
          state_nxt = ST_FIN;
        end else begin
          seg_rd_en  = 1'b1;
          res_ok_nxt = 1'b1;
          state_nxt  = ST_T_PREP;
        end
      end
      ST_SRCH_CMP: begin
        if (seg_start_w <= t_r) begin
          lo_nxt = mid_r;
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = ST_SRCH;
      end
      ST_T_PREP: begin
        dur_nxt     = durp_w;
        div_rem_nxt = tau_num_w[56:25];
        div_dvd_nxt = {tau_num_w[24:0], 39'd0};
        div_quo_nxt = '0;
        div_cnt_nxt = 7'd25;
        state_nxt   = ST_T_DIV;
      end
      ST_T_DIV: begin
        if (div_cnt_r == 7'd1) begin
          state_nxt = ST_H_INIT;
        end
      end
      ST_H_INIT: begin
        tau_nxt = (div_quo_r[24:0] > ppte_pkg::TAU_ONE) ? ppte_pkg::TAU_ONE
                                                       : div_quo_r[24:0];
        p_nxt   = P_W'(COEFF_COUNT - 1);
        for (int i = 0; i < 3; i++) begin
          acc_nxt[i] = '0;
        end
        state_nxt = (32'(k_r) > COEFF_COUNT - 1) ? ST_NORM : ST_H_RD;
      end
      ST_H_RD: begin
        coef_rd_en = 1'b1;
        fall_nxt   = ppte_pkg::falling(4'(p_r), k_r);
        state_nxt  = ST_H_MUL;
      end
      ST_H_MUL: begin
        for (int i = 0; i < 3; i++) begin
          sgn_nxt[i]  = acc_r[i][63];
          ph_nxt[i]   = 57'(acc_abs[i][63:32]) * 57'(tau_r);
          pl_nxt[i]   = 57'(acc_abs[i][31:0]) * 57'(tau_r);
          term_nxt[i] = $signed(coef_rd[i]) * $signed({1'b0, fall_r});
        end
        state_nxt = ST_H_ADD;
      end
      ST_H_ADD: begin
        for (int i = 0; i < 3; i++) begin
          acc_nxt[i] = acc_step[i];
        end
        if (32'(p_r) == 32'(k_r)) begin
          state_nxt = ST_NORM;
        end else begin
          p_nxt     = p_r - 1'b1;
          state_nxt = ST_H_RD;
        end
      end
      ST_NORM: begin
        for (int i = 0; i < 3; i++) begin
          neg_nxt[i] = acc_r[i][63];
          mag_nxt[i] = norm_mag[i];
        end
        ax_nxt    = 2'd0;
        step_nxt  = 3'd0;
        state_nxt = (k_r == 3'd0) ? ST_FIN : ST_S_SETUP;
      end
      ST_S_SETUP: begin
        div_rem_nxt = '0;
        div_dvd_nxt = {mag_r[ax_r], 1'b0};
        div_quo_nxt = '0;
        div_cnt_nxt = 7'd63;
        state_nxt   = ST_S_Q;
      end
      ST_S_Q: begin
        if (div_cnt_r == 7'd1) begin
          state_nxt = ST_S_QEND;
        end
      end
      ST_S_QEND: begin
        if (|div_quo_r[62:46]) begin
          // integer part too large, magnitude is set to the cap
          mag_nxt[ax_r] = ppte_pkg::MAG_CAP;
          if (!last_step) begin
            step_nxt  = step_r + 3'd1;
            state_nxt = ST_S_SETUP;
          end else if (!last_ax) begin
            ax_nxt    = ax_r + 2'd1;
            step_nxt  = 3'd0;
            state_nxt = ST_S_SETUP;
          end else begin
            state_nxt = ST_FIN;
          end
        end else begin
          q1_nxt      = div_quo_r[45:0];
          div_rem_nxt = frac_num_w[47:16];
          div_dvd_nxt = {frac_num_w[15:0], 48'd0};
          div_quo_nxt = '0;
          div_cnt_nxt = 7'd16;
          state_nxt   = ST_S_R;
        end
      end
      ST_S_R: begin
        if (div_cnt_r == 7'd1) begin
          state_nxt = ST_S_REND;
        end
      end
      ST_S_REND: begin
        mag_nxt[ax_r] = scaled_w;
        if (!last_step) begin
          step_nxt  = step_r + 3'd1;
          state_nxt = ST_S_SETUP;
        end else if (!last_ax) begin
          ax_nxt    = ax_r + 2'd1;
          step_nxt  = 3'd0;
          state_nxt = ST_S_SETUP;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        out_valid_nxt              = 1'b1;
        out_data_nxt.found_segment = 4'(lo_r);
        out_data_nxt.result_valid  = res_ok_r;
        out_data_nxt.value_x       = res_ok_r ? sat_val[0] : 48'd0;
        out_data_nxt.value_y       = res_ok_r ? sat_val[1] : 48'd0;
        out_data_nxt.value_z       = res_ok_r ? sat_val[2] : 48'd0;
        state_nxt                  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      segment_count_r  <= '0;
      total_duration_r <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      segment_count_r  <= segment_count_nxt;
      total_duration_r <= total_duration_nxt;
      out_valid_r      <= out_valid_nxt;
    end
    t_r       <= t_nxt;
    k_r       <= k_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    res_ok_r  <= res_ok_nxt;
    dur_r     <= dur_nxt;
    tau_r     <= tau_nxt;
    p_r       <= p_nxt;
    fall_r    <= fall_nxt;
    for (int i = 0; i < 3; i++) begin
      acc_r[i]  <= acc_nxt[i];
      ph_r[i]   <= ph_nxt[i];
      pl_r[i]   <= pl_nxt[i];
      sgn_r[i]  <= sgn_nxt[i];
      term_r[i] <= term_nxt[i];
      neg_r[i]  <= neg_nxt[i];
      mag_r[i]  <= mag_nxt[i];
    end
    ax_r       <= ax_nxt;
    step_r     <= step_nxt;
    q1_r       <= q1_nxt;
    div_rem_r  <= div_rem_nxt;
    div_dvd_r  <= div_dvd_nxt;
    div_quo_r  <= div_quo_nxt;
    div_cnt_r  <= div_cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  a_strobe_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_FIN))
    else $error("result strobe without a finishing query");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    div_run |-> (div_rem_r < dur_r))
    else $error("divider remainder not below divisor");

  a_tau_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_H_MUL) |-> (tau_r <= ppte_pkg::TAU_ONE))
    else $error("tau above one");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.result_valid) |->
      ((out_data.value_x == 48'd0) && (out_data.value_y == 48'd0) &&
       (out_data.value_z == 48'd0)))
    else $error("invalid result carries nonzero values");

endmodule

// ===== bench/tb_piecewise_polynomial_trajectory_eval.sv =====
`timescale 1ns / 1ps
// testbench: table loads, directed and random queries checked against a behavioral trajectory predictor
module tb_piecewise_polynomial_trajectory_eval;

  localparam int SEGS = 16;
  localparam int COEFS = 8;
  localparam int IDLE_WAIT = 1200;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [ppte_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [ppte_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  ppte_pkg::ppte_in_t in_data;
  logic out_valid;
  ppte_pkg::ppte_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [ppte_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_wdata;

  piecewise_polynomial_trajectory_eval i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [4:0] seg_count_q;
  logic [31:0] total_dur_q;
  logic [31:0] start_tab [SEGS];
  logic [31:0] dur_tab [SEGS];
  logic signed [31:0] cx_tab [SEGS*COEFS];
  logic signed [31:0] cy_tab [SEGS*COEFS];
  logic signed [31:0] cz_tab [SEGS*COEFS];
  logic [31:0] load_end;

  ppte_pkg::ppte_out_t expected_q [$];
  int err_cnt = 0;
  int query_cnt = 0;
  int write_cnt = 0;
  int result_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic longint mul_tau(longint a, logic [31:0] tau);
    logic neg;
    logic [63:0] m;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] r;
    neg = a < 0;
    m = neg ? 64'(-a) : 64'(a);
    hi = m >> 32;
    lo = m & 64'hFFFFFFFF;
    r = ((hi * 64'(tau)) << 8) + ((lo * 64'(tau) + 64'h800000) >> 24);
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic [63:0] scale_mag(logic [63:0] m, logic [31:0] dur);
    logic [63:0] q;
    logic [63:0] r;
    q = m / 64'(dur);
    r = m % 64'(dur);
    if (q >= 64'h0000400000000000) return 64'h4000000000000000;
    return (q << 16) + (((r << 16) + 64'(dur >> 1)) / 64'(dur));
  endfunction

  function automatic longint fall_prod(int p, int k);
    longint r;
    r = 1;
    for (int i = 0; i < k; i++) r = r * longint'(p - i);
    return r;
  endfunction

  function automatic logic [47:0] axis_value(int axis, int seg, int k, logic [31:0] tau,
                                            logic [31:0] dur);
    longint acc;
    longint c;
    logic neg;
    logic [63:0] m;
    acc = 0;
    for (int p = COEFS - 1; p >= k; p--) begin
      c = (axis == 0) ? longint'(cx_tab[seg*COEFS+p]) :
          (axis == 1) ? longint'(cy_tab[seg*COEFS+p]) : longint'(cz_tab[seg*COEFS+p]);
      acc = mul_tau(acc, tau) + c * fall_prod(p, k);
    end
    neg = acc < 0;
    m = neg ? 64'(-acc) : 64'(acc);
    m = (m >= 64'h0040000000000000) ? 64'h4000000000000000 : (m << 8);
    for (int i = 0; i < k; i++) m = scale_mag(m, dur);
    if (neg) begin
      if (m > 64'h0000800000000000) m = 64'h0000800000000000;
      return 48'(-m);
    end
    if (m > 64'h00007FFFFFFFFFFF) m = 64'h00007FFFFFFFFFFF;
    return 48'(m);
  endfunction

  function automatic ppte_pkg::ppte_out_t trajectory_point(ppte_pkg::ppte_in_t it);
    ppte_pkg::ppte_out_t r;
    int n;
    int lo;
    int hi;
    int mid;
    int k;
    logic [31:0] t;
    logic [31:0] dur;
    logic [31:0] loc;
    logic [63:0] tau64;
    logic [31:0] tau;
    r = '0;
    n = (seg_count_q > SEGS) ? SEGS : int'(seg_count_q);
    if (n == 0) return r;
    t = (it.query_time > total_dur_q) ? total_dur_q : it.query_time;
    lo = 0;
    hi = n;
    while (lo + 1 < hi) begin
      mid = (lo + hi) / 2;
      if (start_tab[mid] <= t) lo = mid;
      else hi = mid;
    end
    r.found_segment = 4'(lo);
    k = int'(it.deriv_order);
    if (k > ppte_pkg::MAX_DERIV_ORDER) return r;
    dur = (dur_tab[lo] == 0) ? 32'd1 : dur_tab[lo];
    loc = (t < start_tab[lo]) ? 32'd0 : t - start_tab[lo];
    if (loc > dur) loc = dur;
    tau64 = ((64'(loc) << 24) + 64'(dur >> 1)) / 64'(dur);
    tau = (tau64 > 64'h1000000) ? 32'h1000000 : 32'(tau64);
    r.value_x = axis_value(0, lo, k, tau, dur);
    r.value_y = axis_value(1, lo, k, tau, dur);
    r.value_z = axis_value(2, lo, k, tau, dur);
    r.result_valid = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    ppte_pkg::ppte_out_t e;
    if (rst_n && out_valid) begin
      result_cnt++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_data.value_x), 64'd0);
      end else begin
        e = expected_q.pop_front();
        if (out_data.value_x !== e.value_x)
          report_mismatch("value_x", 64'(out_data.value_x), 64'(e.value_x));
        if (out_data.value_y !== e.value_y)
          report_mismatch("value_y", 64'(out_data.value_y), 64'(e.value_y));
        if (out_data.value_z !== e.value_z)
          report_mismatch("value_z", 64'(out_data.value_z), 64'(e.value_z));
        if (out_data.found_segment !== e.found_segment)
          report_mismatch("found_segment", 64'(out_data.found_segment), 64'(e.found_segment));
        if (out_data.result_valid !== e.result_valid)
          report_mismatch("result_valid", 64'(out_data.result_valid), 64'(e.result_valid));
      end
    end
  end

  task automatic send_item(ppte_pkg::ppte_in_t it, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    case (it.req_type)
      ppte_pkg::REQ_TIMING: begin
        start_tab[it.segment_index] = it.start_time;
        dur_tab[it.segment_index] = it.seg_duration;
        write_cnt++;
      end
      ppte_pkg::REQ_COEF: begin
        cx_tab[it.segment_index*COEFS+it.power_index] = it.coef_x;
        cy_tab[it.segment_index*COEFS+it.power_index] = it.coef_y;
        cz_tab[it.segment_index*COEFS+it.power_index] = it.coef_z;
        write_cnt++;
      end
      ppte_pkg::REQ_QUERY: begin
        expected_q.push_back(trajectory_point(it));
        query_cnt++;
      end
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_cfg(logic [ppte_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == ppte_pkg::CFG_SEG_COUNT) seg_count_q = val[4:0];
    else if (idx == ppte_pkg::CFG_TOTAL_DUR) total_dur_q = val;
  endtask

  function automatic ppte_pkg::ppte_in_t random_fields();
    ppte_pkg::ppte_in_t it;
    it.req_type = 2'($urandom_range(0, 3));
    it.segment_index = 4'($urandom);
    it.power_index = 3'($urandom);
    it.start_time = $urandom;
    it.seg_duration = $urandom;
    it.coef_x = $urandom;
    it.coef_y = $urandom;
    it.coef_z = $urandom;
    it.query_time = $urandom;
    it.deriv_order = 3'($urandom);
    return it;
  endfunction

  function automatic logic [31:0] coef_value();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
  endfunction

  task automatic write_timing(int seg, logic [31:0] st, logic [31:0] du, int gap);
    ppte_pkg::ppte_in_t it;
    it = random_fields();
    it.req_type = ppte_pkg::REQ_TIMING;
    it.segment_index = 4'(seg);
    it.start_time = st;
    it.seg_duration = du;
    send_item(it, gap);
  endtask

  task automatic write_coef(int seg, int p, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            int gap);
    ppte_pkg::ppte_in_t it;
    it = random_fields();
    it.req_type = ppte_pkg::REQ_COEF;
    it.segment_index = 4'(seg);
    it.power_index = 3'(p);
    it.coef_x = x;
    it.coef_y = y;
    it.coef_z = z;
    send_item(it, gap);
  endtask

  task automatic query(logic [31:0] t, int k, int gap);
    ppte_pkg::ppte_in_t it;
    it = random_fields();
    it.req_type = ppte_pkg::REQ_QUERY;
    it.query_time = t;
    it.deriv_order = 3'(k);
    send_item(it, gap);
  endtask

  // sorted segment starts with small durations, then all coefficients
  task automatic load_table();
    logic [31:0] t;
    logic [31:0] du;
    t = $urandom_range(1, 32'h20000);
    for (int s = 0; s < SEGS; s++) begin
      du = $urandom_range(1, 32'h40000);
      write_timing(s, t, du, $urandom_range(0, 4));
      t = t + du + $urandom_range(0, 32'h8000);
    end
    load_end = t;
    for (int s = 0; s < SEGS; s++)
      for (int p = 0; p < COEFS; p++)
        write_coef(s, p, coef_value(), coef_value(), coef_value(),
                   (s < 8) ? 0 : $urandom_range(0, 4));
  endtask

  task automatic test_empty_table();
    write_cfg(ppte_pkg::CFG_TOTAL_DUR, 32'hFFFFFFFF);
    query(32'd0, 0, 0);
    query(32'hFFFFFFFF, 7, 2);
    wait_idle();
  endtask

  task automatic test_table_load();
    load_table();
    wait_idle();
    write_cfg(ppte_pkg::CFG_SEG_COUNT, 5'd16);
    write_cfg(ppte_pkg::CFG_TOTAL_DUR, load_end);
  endtask

  task automatic test_special_cases();
    ppte_pkg::ppte_in_t it;
    query(32'd0, 0, 0);
    query(32'hFFFFFFFF, 0, 0);
    for (int k = 0; k < 8; k++) query(start_tab[6] + (dur_tab[6] >> 1), k, k % 3);
    query(start_tab[9] + dur_tab[9] + 1, 1, 1);
    write_timing(3, start_tab[3], 32'd0, 0);
    query(start_tab[3], 2, 0);
    query(start_tab[3] + 5, 0, 1);
    for (int p = 0; p < COEFS; p++)
      write_coef(15, p, 32'h7FFFFFFF, 32'h80000000, (p[0]) ? 32'h7FFFFFFF : 32'h80000000, 0);
    write_timing(15, start_tab[15], 32'd1, 0);
    for (int k = 0; k < 5; k++) query(32'hFFFFFFFF, k, 0);
    it = random_fields();
    it.req_type = REQ_UNUSED;
    send_item(it, 1);
    wait_idle();
    write_cfg(CFG_SPARE_A, $urandom);
    write_cfg(CFG_SPARE_B, $urandom);
    query(start_tab[2], 0, 0);
    wait_idle();
  endtask

  task automatic random_phase(logic [4:0] cnt, logic [31:0] total, int items);
    ppte_pkg::ppte_in_t it;
    int sel;
    int burst;
    wait_idle();
    write_cfg(ppte_pkg::CFG_SEG_COUNT, cnt);
    write_cfg(ppte_pkg::CFG_TOTAL_DUR, total);
    burst = 0;
    for (int i = 0; i < items; i++) begin
      if (i % 32 == 0) burst = $urandom_range(0, 2) == 0;
      it = random_fields();
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        it.req_type = ppte_pkg::REQ_QUERY;
        if ($urandom_range(0, 3) != 0) it.query_time = $urandom_range(0, load_end + 32'h10000);
        if ($urandom_range(0, 4) != 0) it.deriv_order = 3'($urandom_range(0, 4));
      end else if (sel < 85) begin
        it.req_type = ppte_pkg::REQ_COEF;
        it.coef_x = coef_value();
        it.coef_y = coef_value();
        it.coef_z = coef_value();
      end else if (sel < 95) begin
        it.req_type = ppte_pkg::REQ_TIMING;
        if ($urandom_range(0, 2) != 0) begin
          it.start_time = start_tab[it.segment_index];
          it.seg_duration = $urandom_range(0, 32'h40000);
        end
      end else begin
        it.req_type = REQ_UNUSED;
      end
      send_item(it, burst ? 0 : $urandom_range(0, 4));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = ppte_pkg::CFG_SEG_COUNT;
    cfg_wdata = '0;
    seg_count_q = '0;
    total_dur_q = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_table_load();
    test_special_cases();
    random_phase(5'd16, load_end, 130);
    random_phase(5'd5, $urandom, 120);
    random_phase(5'd31, 32'hFFFFFFFF, 120);
    random_phase(5'd1, 32'd0, 60);
    random_phase(5'd11, load_end >> 1, 100);
    wait_idle();
    if (expected_q.size() != 0) err_cnt++;
    $display("covered %0d queries and %0d table writes, %0d results checked",
             query_cnt, write_cnt, result_cnt);
    $display("tables: empty, partial and full, zero and maximum clamp times");
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ppte_pkg.sv
sv/ppte_ram.sv
sv/piecewise_polynomial_trajectory_eval.sv
bench/tb_piecewise_polynomial_trajectory_eval.sv
